### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the rtl.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while in reset
`define FMP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked implication, disabled while in reset
`define FMP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### hw/rtl/fmp_pkg.sv
// ----------------------------------------------------------------------------
// fmp_pkg
// Types and constants shared by the fibonacci matrix power blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package fmp_pkg;

    localparam int unsigned VAL_W     = 31;
    localparam int unsigned STEP_W    = $clog2(VAL_W + 1);
    localparam logic [VAL_W-1:0] MOD_RESET = 31'd1000000007;

    typedef logic [VAL_W-1:0] val_t;

    typedef struct packed {
        val_t e00;
        val_t e01;
        val_t e10;
        val_t e11;
    } mat_t;

    localparam mat_t MAT_IDENT = '{e00: 31'd1, e01: 31'd0, e10: 31'd0, e11: 31'd1};
    localparam mat_t MAT_BASE  = '{e00: 31'd0, e01: 31'd1, e10: 31'd1, e11: 31'd1};

    // request to the modular multiplier: result = (a * b + c) mod m
    typedef struct packed {
        logic start;
        val_t a;
        val_t b;
        val_t c;
        val_t m;
    } mm_req_t;

    typedef struct packed {
        logic done;
        logic busy;
        val_t result;
    } mm_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/fmp_if.sv
// ----------------------------------------------------------------------------
// fmp_if
// Valid/ready channels for the index input and the value output.
// ----------------------------------------------------------------------------
`default_nettype none

interface fmp_idx_if;
    logic          valid;
    logic          ready;
    fmp_pkg::val_t fib_index;

    modport source (output valid, output fib_index, input ready);
    modport sink   (input valid, input fib_index, output ready);
endinterface

interface fmp_val_if;
    logic          valid;
    logic          ready;
    fmp_pkg::val_t fib_value;

    modport source (output valid, output fib_value, input ready);
    modport sink   (input valid, input fib_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/fibonacci_matrix_power_mod_unit.sv
// ----------------------------------------------------------------------------
// fibonacci_matrix_power_mod_unit
// F(n) mod m by powering [[0,1],[1,1]] with square-and-multiply, all entry
// products on one shared bit-serial modular multiply-add unit.
// ----------------------------------------------------------------------------
//  channel   dir   handshake       payload
//  idx_ch    in    valid/ready     fib_index (31 b)
//  val_ch    out   valid/ready     fib_value (31 b)
//  cfg       in    cfg_wr_en       cfg_wr_data -> modulus (31 b)
//
//  each multiply-add runs on the shared unit as start, 31 bit steps, addend
//  step and done, and a matrix product takes 8 of them plus a pass through
//  the step state
//  an item takes up to 2*INDEX_WIDTH-1 matrix products; for index 0 the
//  result leaves through the step state, and for a modulus below 2 the
//  result 0 is offered in the cycle after the input transfer
//  one item at a time: idx_ch.ready is high only when idle, the result is
//  held on val_ch until its transfer
//  asynchronous active-low reset, modulus resets to 1000000007
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fibonacci_matrix_power_mod_unit #(
    parameter int unsigned INDEX_WIDTH = 31
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wr_en,
    input  wire fmp_pkg::val_t cfg_wr_data,
    fmp_idx_if.sink            idx_ch,
    fmp_val_if.source          val_ch
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_STEP = 4'b0010,
        S_MUL  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    fmp_pkg::val_t            modulus_reg, modulus_next;
    logic [INDEX_WIDTH-1:0]   n_reg, n_next;
    fmp_pkg::mat_t            acc_reg, acc_next;
    fmp_pkg::mat_t            base_reg, base_next;
    fmp_pkg::mat_t            tmp_reg, tmp_next;
    fmp_pkg::val_t            p0_reg, p0_next;
    fmp_pkg::val_t            out_reg, out_next;
    logic                     mul_acc_reg, mul_acc_next;
    logic [1:0]               ent_reg, ent_next;
    logic                     k_reg, k_next;
    logic                     start_reg, start_next;

    fmp_pkg::mm_req_t         mm_req;
    fmp_pkg::mm_rsp_t         mm_rsp;
    fmp_pkg::mat_t            lhs;
    fmp_pkg::val_t            op_a;
    fmp_pkg::val_t            op_b;
    fmp_pkg::mat_t            prod;

    fmp_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .rsp   (mm_rsp)
    );

    // operand selection for entry (r,c) = ent, inner term k
    always_comb
    begin
        lhs = mul_acc_reg ? acc_reg : base_reg;
        unique case ({ent_reg, k_reg})
            3'b000:  begin op_a = lhs.e00; op_b = base_reg.e00; end
            3'b001:  begin op_a = lhs.e01; op_b = base_reg.e10; end
            3'b010:  begin op_a = lhs.e00; op_b = base_reg.e01; end
            3'b011:  begin op_a = lhs.e01; op_b = base_reg.e11; end
            3'b100:  begin op_a = lhs.e10; op_b = base_reg.e00; end
            3'b101:  begin op_a = lhs.e11; op_b = base_reg.e10; end
            3'b110:  begin op_a = lhs.e10; op_b = base_reg.e01; end
            default: begin op_a = lhs.e11; op_b = base_reg.e11; end
        endcase
    end

    always_comb
    begin
        mm_req.start = start_reg;
        mm_req.a     = op_a;
        mm_req.b     = op_b;
        mm_req.c     = k_reg ? p0_reg : '0;
        mm_req.m     = modulus_reg;
    end

    // completed product, last entry taken straight from the unit
    always_comb
    begin
        prod     = tmp_reg;
        prod.e11 = mm_rsp.result;
    end

    always_comb
    begin
        state_next   = state_reg;
        modulus_next = cfg_wr_en ? cfg_wr_data : modulus_reg;
        n_next       = n_reg;
        acc_next     = acc_reg;
        base_next    = base_reg;
        tmp_next     = tmp_reg;
        p0_next      = p0_reg;
        out_next     = out_reg;
        mul_acc_next = mul_acc_reg;
        ent_next     = ent_reg;
        k_next       = k_reg;
        start_next   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (idx_ch.valid)
                begin
                    n_next    = INDEX_WIDTH'(idx_ch.fib_index);
                    acc_next  = fmp_pkg::MAT_IDENT;
                    base_next = fmp_pkg::MAT_BASE;
                    if (modulus_reg <= fmp_pkg::VAL_W'(1))
                    begin
                        out_next   = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_STEP;
                    end
                end
            end
            S_STEP:
            begin
                if (n_reg == '0)
                begin
                    out_next   = acc_reg.e01;
                    state_next = S_OUT;
                end
                else
                begin
                    mul_acc_next = n_reg[0];
                    ent_next     = 2'd0;
                    k_next       = 1'b0;
                    start_next   = 1'b1;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mm_rsp.done)
                begin
                    if (!k_reg)
                    begin
                        p0_next    = mm_rsp.result;
                        k_next     = 1'b1;
                        start_next = 1'b1;
                    end
                    else
                    begin
                        unique case (ent_reg)
                            2'd0:    tmp_next.e00 = mm_rsp.result;
                            2'd1:    tmp_next.e01 = mm_rsp.result;
                            2'd2:    tmp_next.e10 = mm_rsp.result;
                            default: tmp_next.e11 = mm_rsp.result;
                        endcase
                        if (ent_reg == 2'd3)
                        begin
                            if (mul_acc_reg)
                            begin
                                acc_next = prod;
                                n_next   = n_reg - 1'b1;
                            end
                            else
                            begin
                                base_next = prod;
                                n_next    = n_reg >> 1;
                            end
                            state_next = S_STEP;
                        end
                        else
                        begin
                            ent_next   = ent_reg + 2'd1;
                            k_next     = 1'b0;
                            start_next = 1'b1;
                        end
                    end
                end
            end
            S_OUT:
            begin
                if (val_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            modulus_reg <= fmp_pkg::MOD_RESET;
            start_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            modulus_reg <= modulus_next;
            start_reg   <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        acc_reg     <= acc_next;
        base_reg    <= base_next;
        tmp_reg     <= tmp_next;
        p0_reg      <= p0_next;
        out_reg     <= out_next;
        mul_acc_reg <= mul_acc_next;
        ent_reg     <= ent_next;
        k_reg       <= k_next;
    end

    assign idx_ch.ready     = (state_reg == S_IDLE);
    assign val_ch.valid     = (state_reg == S_OUT);
    assign val_ch.fib_value = out_reg;

    `FMP_ASSERT(a_one_side, !(idx_ch.ready && val_ch.valid), "input and output open together")
    `FMP_ASSERT_IMP(a_done_in_mul, mm_rsp.done, state_reg == S_MUL, "product done outside run")
    `FMP_ASSERT_IMP(a_start_idle_unit, start_reg, !mm_rsp.busy && state_reg == S_MUL, "start while unit busy")

endmodule

`default_nettype wire

### hw/rtl/fmp_mulmod.sv
// ----------------------------------------------------------------------------
// fmp_mulmod
// Bit-serial interleaved modular multiply-add, one multiplier bit a cycle,
// then a final step that adds the addend.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fmp_mulmod (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire fmp_pkg::mm_req_t req,
    output fmp_pkg::mm_rsp_t     rsp
);

    localparam logic [fmp_pkg::STEP_W-1:0] LAST_STEP = fmp_pkg::STEP_W'(fmp_pkg::VAL_W);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [fmp_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    fmp_pkg::val_t               a_reg, a_next;
    fmp_pkg::val_t               b_reg, b_next;
    fmp_pkg::val_t               c_reg, c_next;
    fmp_pkg::val_t               m_reg, m_next;
    fmp_pkg::val_t               r_reg, r_next;

    logic                        last;
    logic [fmp_pkg::VAL_W:0]     m_ext;
    logic [fmp_pkg::VAL_W:0]     dbl;
    logic [fmp_pkg::VAL_W:0]     dbl_red;
    logic [fmp_pkg::VAL_W:0]     base_v;
    logic [fmp_pkg::VAL_W:0]     addend;
    logic [fmp_pkg::VAL_W:0]     sum;
    logic [fmp_pkg::VAL_W:0]     sum_red;

    // r stays below m, so each partial sum stays below 2m
    always_comb
    begin
        last    = (cnt_reg == LAST_STEP);
        m_ext   = {1'b0, m_reg};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
        base_v  = last ? {1'b0, r_reg} : dbl_red;
        if (last)
        begin
            addend = {1'b0, c_reg};
        end
        else
        begin
            addend = b_reg[fmp_pkg::VAL_W-1] ? {1'b0, a_reg} : '0;
        end
        sum     = base_v + addend;
        sum_red = (sum >= m_ext) ? sum - m_ext : sum;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = req.a;
            b_next    = req.b;
            c_next    = req.c;
            m_next    = req.m;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next = sum_red[fmp_pkg::VAL_W-1:0];
            b_next = {b_reg[fmp_pkg::VAL_W-2:0], 1'b0};
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        m_reg <= m_next;
        r_reg <= r_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.busy   = busy_reg;
    assign rsp.result = r_reg;

    `FMP_ASSERT_IMP(a_mm_done_reduced, done_reg, r_reg < m_reg, "mulmod result not reduced")
    `FMP_ASSERT_IMP(a_mm_done_pulse, done_reg, !busy_reg && $past(busy_reg), "done without run")
    `FMP_ASSERT_IMP(a_mm_cnt_range, busy_reg, cnt_reg <= LAST_STEP, "step count overrun")

endmodule

`default_nettype wire

### tb/tb_fibonacci_matrix_power_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fibonacci_matrix_power_mod_unit
// Sends Fibonacci indices under a series of modulus settings and checks each
// returned value against an in-bench square-and-multiply predictor, with
// random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fibonacci_matrix_power_mod_unit;

    typedef fmp_pkg::val_t val_t;

    localparam int unsigned IDX_BITS      = 31;
    localparam int          IDLE_LIMIT    = 200000;
    localparam int          RANDOM_PER_MOD = 40;

    class fib_scoreboard;
        val_t           expected_values[$];
        longint unsigned modulus;
        int             errors;

        function new();
            modulus = fmp_pkg::MOD_RESET;
            errors  = 0;
        endfunction

        function void set_modulus(val_t m);
            modulus = m;
        endfunction

        // 2x2 matrix powering, products at 64 bits, sums reduced again
        function val_t fib_residue(val_t index);
            longint unsigned acc[4];
            longint unsigned bas[4];
            longint unsigned t[4];
            longint unsigned n;
            longint unsigned m;
            m = modulus;
            if (m <= 1)
                return '0;
            acc = '{1, 0, 0, 1};
            bas = '{0, 1, 1, 1};
            n = index & ((64'd1 << IDX_BITS) - 1);
            while (n != 0)
            begin
                if (n[0] == 1'b0)
                begin
                    n = n >> 1;
                    for (int k = 0; k < 4; k++)
                        t[k] = ((bas[(k/2)*2] * bas[k%2]) % m
                                + (bas[(k/2)*2+1] * bas[2+k%2]) % m) % m;
                    bas = t;
                end
                else
                begin
                    n = n - 1;
                    for (int k = 0; k < 4; k++)
                        t[k] = ((acc[(k/2)*2] * bas[k%2]) % m
                                + (acc[(k/2)*2+1] * bas[2+k%2]) % m) % m;
                    acc = t;
                end
            end
            return val_t'(acc[1] % m);
        endfunction

        function void note_index(val_t index);
            expected_values = {expected_values, fib_residue(index)};
        endfunction

        function void check_value(val_t got);
            val_t want;
            if (expected_values.size() == 0)
            begin
                $display("%0t: unexpected fib_value transfer, actual %0d", $time, got);
                errors++;
                return;
            end
            want = expected_values.pop_front();
            if (got !== want)
            begin
                $display("%0t: fib_value mismatch, expected %0d, actual %0d",
                         $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_values.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    val_t cfg_wr_data;

    fmp_idx_if idx_ch ();
    fmp_val_if val_ch ();

    fib_scoreboard fib_sb;
    int            idle_cycles;
    int            stall_left;

    fibonacci_matrix_power_mod_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .idx_ch      (idx_ch),
        .val_ch      (val_ch)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 120);
    endfunction

    // mostly short indices, the block takes up to two matrix products per bit
    function automatic val_t pick_index();
        int w;
        if ($urandom_range(0, 99) < 6)
            return val_t'($urandom);
        w = $urandom_range(1, 8);
        return val_t'($urandom & ((32'd1 << w) - 1));
    endfunction

    // result side: random stalls, occasionally long ones
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (val_ch.valid && val_ch.ready)
                fib_sb.check_value(val_ch.fib_value);
            if (stall_left > 0)
            begin
                stall_left   <= stall_left - 1;
                val_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 3)
            begin
                stall_left   <= $urandom_range(20, 150);
                val_ch.ready <= 1'b0;
            end
            else
                val_ch.ready <= ($urandom_range(0, 99) < 75);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((idx_ch.valid && idx_ch.ready) || (val_ch.valid && val_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_index(input val_t index);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            idx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        idx_ch.valid     <= 1'b1;
        idx_ch.fib_index <= index;
        do
            @(posedge clk);
        while (!idx_ch.ready);
        fib_sb.note_index(index);
    endtask

    task automatic write_modulus(input val_t m);
        idx_ch.valid <= 1'b0;
        while (fib_sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        fib_sb.set_modulus(m);
    endtask

    task automatic random_run(input int count);
        for (int i = 0; i < count; i++)
            send_index(pick_index());
    endtask

    initial
    begin
        val_t moduli[$];
        fib_sb           = new();
        idle_cycles      = 0;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        idx_ch.valid     = 1'b0;
        idx_ch.fib_index = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: index extremes, bit patterns, small known values
        send_index(31'd0);
        send_index(31'd1);
        send_index(31'd2);
        send_index(31'd3);
        send_index(31'd10);
        send_index(31'd47);
        send_index(31'd93);
        send_index(31'h7FFFFFFF);
        send_index(31'h40000000);
        send_index(31'h55555555);
        send_index(31'h2AAAAAAA);
        random_run(RANDOM_PER_MOD);

        // smallest legal, largest, out-of-range zero and one, then 3 and a random one
        moduli = '{31'd2, 31'h7FFFFFFF, 31'd0, 31'd1, 31'd3,
                   val_t'($urandom_range(2, 32'h7FFFFFFF))};
        foreach (moduli[i])
        begin
            write_modulus(moduli[i]);
            send_index(31'd0);
            send_index(31'h7FFFFFFF);
            random_run(RANDOM_PER_MOD);
        end

        idx_ch.valid <= 1'b0;
        while (fib_sb.pending() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fib_sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
+incdir+hw/rtl
hw/rtl/fmp_pkg.sv
hw/rtl/fmp_if.sv
hw/rtl/fmp_mulmod.sv
hw/rtl/fibonacci_matrix_power_mod_unit.sv
tb/tb_fibonacci_matrix_power_mod_unit.sv
